// ----- design/fsqrt_pkg.sv -----
// Shared constants and types for the single-precision square root pipeline.
package fsqrt_pkg;
  localparam int unsigned RootSteps = 25;
  localparam int unsigned RemW = 27;
  localparam logic [31:0] ExpMask = 32'h7f800000;
  localparam logic [31:0] NegInf = 32'hff800000;
  localparam logic [31:0] SignBit = 32'h80000000;
  localparam logic [31:0] HiddenBit = 32'h00800000;
  localparam logic [31:0] FracMask = 32'h007fffff;
  localparam logic [31:0] QuietBit = 32'h00400000;
  localparam logic [31:0] TopBit = 32'h01000000;
  localparam logic [31:0] HalfBias = 32'h3f000000;
  localparam logic [31:0] DefaultNan = 32'h7fc00000;
  localparam logic [8:0] ExpBias = 9'd127;

  typedef enum logic [1:0] {
    RM_NEAREST = 2'd0,
    RM_ZERO    = 2'd1,
    RM_DOWN    = 2'd2,
    RM_UP      = 2'd3
  } round_mode_t;

  // control travelling alongside the recurrence
  typedef struct packed {
    logic        valid;
    logic        special;
    logic [31:0] spec_bits;
    logic        spec_inv;
    logic [7:0]  half;
    logic [1:0]  mode;
  } fsqrt_ctl_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [RemW-1:0] acc;
    logic [24:0]     q;
  } fsqrt_dat_t;
endpackage

// ----- design/fsqrt_cell.sv -----
// One restoring-root step with its pipeline register.
module fsqrt_cell import fsqrt_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  fsqrt_ctl_t ctl_in,
  input  fsqrt_dat_t dat_in,
  output fsqrt_ctl_t ctl_out,
  output fsqrt_dat_t dat_out
);
  localparam logic [RemW-1:0] Bit = RemW'(1) << (RootSteps - 1 - Step);
  fsqrt_ctl_t ctl_r;
  fsqrt_dat_t dat_r, dat_nxt;
  logic [RemW-1:0] trial, rem_t;

  always_comb begin
    trial = dat_in.acc + Bit;
    dat_nxt = dat_in;
    rem_t = dat_in.rem;
    if (trial <= dat_in.rem) begin
      dat_nxt.acc = trial + Bit;
      rem_t = dat_in.rem - trial;
      dat_nxt.q = dat_in.q | Bit[24:0];
    end
    dat_nxt.rem = {rem_t[RemW-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_in.valid;
    end
    ctl_r.special <= ctl_in.special;
    ctl_r.spec_bits <= ctl_in.spec_bits;
    ctl_r.spec_inv <= ctl_in.spec_inv;
    ctl_r.half <= ctl_in.half;
    ctl_r.mode <= ctl_in.mode;
    dat_r <= dat_nxt;
  end

  assign ctl_out = ctl_r;
  assign dat_out = dat_r;
endmodule

// ----- design/fsqrt_prep.sv -----
// Operand decode, special cases and normalisation stage.
module fsqrt_prep import fsqrt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        valid,
  input  logic [31:0] a,
  input  logic [1:0]  mode,
  output fsqrt_ctl_t  ctl_out,
  output fsqrt_dat_t  dat_out
);
  fsqrt_ctl_t ctl_r, ctl_nxt;
  fsqrt_dat_t dat_r, dat_nxt;
  logic [4:0]  lz;
  logic [22:0] frac;
  logic [23:0] sig;
  logic [8:0]  lead, e;

  always_comb begin
    frac = a[22:0];
    lz = 5'd0;
    for (int i = 22; i >= 0; i--) begin
      if (frac[i] && lz == 5'd0 && (frac >> (i + 1)) == 23'd0) lz = 5'(23 - i);
    end
    if (a[30:23] == 8'd0) begin
      sig = {1'b0, frac} << lz;
      lead = 9'd1 - {4'd0, lz};
    end else begin
      sig = {1'b1, frac};
      lead = {1'b0, a[30:23]};
    end
    sig[23] = 1'b1;
    e = lead - ExpBias;
    ctl_nxt.valid = valid;
    ctl_nxt.mode = mode;
    ctl_nxt.half = 8'(($signed(e) >>> 1));
    ctl_nxt.special = 1'b1;
    ctl_nxt.spec_inv = 1'b0;
    ctl_nxt.spec_bits = a;
    if ((a & ExpMask) == ExpMask) begin
      if (a == NegInf) begin
        ctl_nxt.spec_bits = DefaultNan;
        ctl_nxt.spec_inv = 1'b1;
      end else if ((a & FracMask) != 32'd0) begin
        ctl_nxt.spec_bits = a | QuietBit;
        ctl_nxt.spec_inv = ~a[22];
      end
    end else if ((a & ~SignBit) == 32'd0) begin
      ctl_nxt.spec_bits = a;
    end else if (a[31]) begin
      ctl_nxt.spec_bits = DefaultNan;
      ctl_nxt.spec_inv = 1'b1;
    end else begin
      ctl_nxt.special = 1'b0;
    end
    dat_nxt.acc = '0;
    dat_nxt.q = '0;
    dat_nxt.rem = e[0] ? {1'b0, sig, 2'b0} : {2'b0, sig, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_nxt.valid;
    end
    ctl_r.special <= ctl_nxt.special;
    ctl_r.spec_bits <= ctl_nxt.spec_bits;
    ctl_r.spec_inv <= ctl_nxt.spec_inv;
    ctl_r.half <= ctl_nxt.half;
    ctl_r.mode <= ctl_nxt.mode;
    dat_r <= dat_nxt;
  end

  assign ctl_out = ctl_r;
  assign dat_out = dat_r;
endmodule

// ----- design/float32_square_root_top.sv -----
// Top level of the pipelined single-precision square root.
// Usage:
//   Write cfg_round_mode with cfg_wr_en (0 nearest even, 1 toward zero,
//   2 downward, 3 upward) while no request is in flight.
//   Raise start with in_operand_bits; busy is always low, so a request
//   is taken in every cycle start is high.
//   The result appears on out_root_bits, out_invalid_flag and
//   out_inexact_flag for one cycle with out_valid high, after the
//   request passes one decode stage, 25 root cells (one result bit
//   each) and one rounding stage.
//   Throughput is one request per cycle; the cell row is fully pipelined.
//   Reset clears the valid bits of every stage and the rounding mode.
//   The receiver cannot stall; results are always delivered on time.
module float32_square_root_top import fsqrt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_operand_bits,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_round_mode,
  output logic        out_valid,
  output logic [31:0] out_root_bits,
  output logic        out_invalid_flag,
  output logic        out_inexact_flag
);
  logic [1:0] mode_r;
  fsqrt_ctl_t ctl [RootSteps+1];
  fsqrt_dat_t dat [RootSteps+1];
  fsqrt_ctl_t lc;
  fsqrt_dat_t ld;
  logic [25:0] qr;
  logic [31:0] res_nxt, res_r;
  logic inx, inv_nxt, inx_nxt, inv_r, inx_r, val_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= RM_NEAREST;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_round_mode;
    end
  end

  fsqrt_prep u_prep (
    .clk(clk), .rst_n(rst_n), .valid(start), .a(in_operand_bits), .mode(mode_r),
    .ctl_out(ctl[0]), .dat_out(dat[0])
  );

  for (genvar g = 0; g < RootSteps; g++) begin : g_cell
    fsqrt_cell #(.Step(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl_in(ctl[g]), .dat_in(dat[g]),
      .ctl_out(ctl[g+1]), .dat_out(dat[g+1])
    );
  end

  assign lc = ctl[RootSteps];
  assign ld = dat[RootSteps];

  always_comb begin
    inx = ld.rem != '0;
    qr = {1'b0, ld.q};
    if (inx) begin
      case (lc.mode)
        RM_NEAREST: qr = {1'b0, ld.q} + {25'd0, ld.q[0]};
        RM_UP:      qr = {1'b0, ld.q} + 26'd2;
        default:    qr = {1'b0, ld.q};
      endcase
    end
    if (lc.special) begin
      res_nxt = lc.spec_bits;
      inv_nxt = lc.spec_inv;
      inx_nxt = 1'b0;
    end else begin
      res_nxt = {7'd0, qr[25:1]} + HalfBias + {lc.half[7], lc.half, 23'd0};
      inv_nxt = 1'b0;
      inx_nxt = inx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 1'b0;
    end else begin
      val_r <= lc.valid;
    end
    res_r <= res_nxt;
    inv_r <= inv_nxt;
    inx_r <= inx_nxt;
  end

  assign out_valid = val_r;
  assign out_root_bits = res_r;
  assign out_invalid_flag = inv_r;
  assign out_inexact_flag = inx_r;

  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start ##(RootSteps + 2) 1'b1 |-> out_valid)
    else $error("result missing");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid_flag |-> !out_inexact_flag)
    else $error("both flags set");
endmodule

// ----- sim/tb_float32_square_root_top.sv -----
// Self-checking testbench for the pipelined single-precision square root.
module tb_float32_square_root_top;
  import fsqrt_pkg::*;

  localparam int unsigned Latency = 27;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [31:0] root;
    logic        inv;
    logic        inx;
  } sqrt_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_operand_bits = '0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_round_mode = RM_NEAREST;
  logic        out_valid;
  logic [31:0] out_root_bits;
  logic        out_invalid_flag;
  logic        out_inexact_flag;

  logic [31:0] pending_ops[$];
  sqrt_res_t   expected_roots[$];
  round_mode_t mode_now = RM_NEAREST;
  int unsigned mismatches = 0;
  int unsigned roots_checked = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned inexact_seen = 0;
  int unsigned invalid_seen = 0;

  float32_square_root_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operand_bits(in_operand_bits), .cfg_wr_en(cfg_wr_en),
    .cfg_round_mode(cfg_round_mode), .out_valid(out_valid),
    .out_root_bits(out_root_bits), .out_invalid_flag(out_invalid_flag),
    .out_inexact_flag(out_inexact_flag)
  );

  always #5 clk = ~clk;

  function automatic sqrt_res_t predict_root(logic [31:0] a, round_mode_t mode);
    sqrt_res_t r;
    logic [31:0] sig, rem, acc, q, bit_w, trial, res;
    int lead, sh, e, k, half;
    r = '0;
    if ((a & ExpMask) == ExpMask) begin
      if (a == NegInf) begin
        r.root = DefaultNan;
        r.inv = 1'b1;
      end else if ((a & FracMask) != 0) begin
        r.root = a | QuietBit;
        r.inv = ((a & QuietBit) == 0);
      end else begin
        r.root = a;
      end
      return r;
    end
    if ((a & ~SignBit) == 0) begin
      r.root = a;
      return r;
    end
    if ((a & SignBit) != 0) begin
      r.root = DefaultNan;
      r.inv = 1'b1;
      return r;
    end
    lead = int'(a >> 23);
    sig = a;
    if (lead == 0) begin
      sh = 0;
      while ((sig & HiddenBit) == 0) begin
        sig = sig << 1;
        sh++;
      end
      lead = 1 - sh;
    end
    e = lead - 127;
    sig = (sig & FracMask) | HiddenBit;
    k = e + 256;
    if (k[0]) sig = sig + sig;
    half = (k >>> 1) - 128;
    rem = sig + sig;
    acc = 0;
    q = 0;
    bit_w = TopBit;
    while (bit_w != 0) begin
      trial = acc + bit_w;
      if (trial <= rem) begin
        acc = trial + bit_w;
        rem = rem - trial;
        q = q + bit_w;
      end
      rem = rem + rem;
      bit_w = bit_w >> 1;
    end
    if (rem != 0) begin
      if (mode == RM_NEAREST) q = q + (q & 1);
      else if (mode == RM_UP) q = q + 2;
    end
    res = (q >> 1) + HalfBias;
    res = res + (32'(half) << 23);
    r.root = res;
    r.inx = (rem != 0);
    return r;
  endfunction

  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'hff;
      1: v[30:23] = 8'h00;
      2: v[31] = 1'b1;
      default: v[31] = 1'b0;
    endcase
    return v;
  endfunction

  // driver: bursts of requests separated by random gaps
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (pending_ops.size() != 0) begin
      start <= 1'b1;
      in_operand_bits <= pending_ops[0];
      expected_roots.push_back(predict_root(pending_ops[0], mode_now));
      void'(pending_ops.pop_front());
      if (burst_left == 0) begin
        burst_left <= $urandom_range(0, 20);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    sqrt_res_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_roots.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected root %h", out_root_bits);
      end else begin
        exp_r = expected_roots.pop_front();
        roots_checked <= roots_checked + 1;
        if (exp_r.inx) inexact_seen <= inexact_seen + 1;
        if (exp_r.inv) invalid_seen <= invalid_seen + 1;
        if (exp_r.root !== out_root_bits || exp_r.inv !== out_invalid_flag ||
            exp_r.inx !== out_inexact_flag) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected %h inv %b inx %b, got %h inv %b inx %b",
                     exp_r.root, exp_r.inv, exp_r.inx, out_root_bits,
                     out_invalid_flag, out_inexact_flag);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic drain();
    while (pending_ops.size() != 0 || expected_roots.size() != 0 || start)
      @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic set_mode(round_mode_t m);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_round_mode <= m;
    mode_now <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    round_mode_t modes[4];
    logic [31:0] directed[$];
    modes = '{RM_NEAREST, RM_UP, RM_ZERO, RM_DOWN};
    directed = '{32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000,
                 32'h7fc00001, 32'h7f800001, 32'hffbfffff, 32'hffffffff,
                 32'h00000001, 32'h007fffff, 32'h00800000, 32'h7f7fffff,
                 32'h3f800000, 32'h40000000, 32'h40800000, 32'h3f7fffff,
                 32'hbf800000, 32'h80000001, 32'h40400000, 32'h4f7fffff,
                 32'hffffffff ^ 32'h80000000, 32'h00400000};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (modes[i]) begin
      drain();
      set_mode(modes[i]);
      foreach (directed[j]) pending_ops.push_back(directed[j]);
      repeat (120) pending_ops.push_back(random_operand());
    end
    drain();
    $display("checked %0d roots over all four rounding modes", roots_checked);
    $display("%0d inexact, %0d invalid results", inexact_seen, invalid_seen);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
